// ----- hdl/assert_macros.svh -----
// assertion macros used by cross_linked_ppi_port_pair_unit
// each macro samples on i_clk; only CHECK_PROP is disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CHECK_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// same check, also evaluated during reset
`define CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/clppi_pkg.sv -----
// types, port addresses and access codes for the linked parallel port pair
// no dependencies
`timescale 1ns / 1ps

package clppi_pkg;

    // access codes carried in the mode field
    localparam logic [1:0] MODE_DISK_RD = 2'd0;
    localparam logic [1:0] MODE_DISK_WR = 2'd1;
    localparam logic [1:0] MODE_HOST_RD = 2'd2;
    localparam logic [1:0] MODE_HOST_WR = 2'd3;

    // i/o port addresses on both sides
    localparam logic [7:0] PORT_A   = 8'hFC;
    localparam logic [7:0] PORT_B   = 8'hFD;
    localparam logic [7:0] PORT_C   = 8'hFE;
    localparam logic [7:0] PORT_CTL = 8'hFF;

    localparam logic [7:0] READ_IDLE = 8'hFF;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] port_address;
        logic [7:0] write_data;
    } t_access;

    typedef struct packed {
        logic [7:0] read_data;
        logic       handled;
        logic       wake_request;
    } t_result;

    // control byte applied to a port c image: mode set clears, else bit set/reset
    function automatic logic [7:0] fn_apply_control(input logic [7:0] portc,
                                                    input logic [7:0] ctl);
        logic [7:0] bit_mask;
        bit_mask = 8'h01 << ctl[3:1];
        if (ctl[7]) begin
            return 8'h00;
        end else if (ctl[0]) begin
            return portc | bit_mask;
        end else begin
            return portc & ~bit_mask;
        end
    endfunction

endpackage

// ----- hdl/clppi_stream_if.sv -----
// valid/ready channel carrying one word of a given payload type
// payload types come from clppi_pkg
`timescale 1ns / 1ps

interface clppi_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/cross_linked_ppi_port_pair_unit.sv -----
// channel  dir  payload                                   handshake
// i_acc    in   mode, port_address, write_data (t_access) valid/ready
// o_res    out  read_data, handled, wake_request (t_result) valid/ready
//
// one word per cycle sustained while the result channel is not stalled
// stage one holds the accepted access, the port decode and state update sit
// between it and the result register
// i_rst_n is synchronous, active low, and clears all port state to zero
// a stalled result holds the result register; stage one refills behind it
// depends on clppi_pkg, clppi_stream_if and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cross_linked_ppi_port_pair_unit
    import clppi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    clppi_stream_if.sink          i_acc,
    clppi_stream_if.source        o_res
);

    logic       r_in_valid;
    t_access    r_in;
    logic       r_out_valid;
    t_result    r_out;

    logic [7:0] r_disk_port_b_out,     n_disk_port_b_out;
    logic [7:0] r_disk_port_c_bits,    n_disk_port_c_bits;
    logic [3:0] r_disk_to_host_nibble, n_disk_to_host_nibble;
    logic [7:0] r_host_port_b_to_disk, n_host_port_b_to_disk;
    logic [7:0] r_host_port_c_bits,    n_host_port_c_bits;
    logic [3:0] r_host_to_disk_nibble, n_host_to_disk_nibble;
    logic [7:0] r_disk_control_last,   n_disk_control_last;

    t_result    n_out;
    logic       w_out_adv;
    logic       w_in_adv;

    assign w_out_adv   = !r_out_valid || o_res.ready;
    assign w_in_adv    = r_in_valid && w_out_adv;
    assign i_acc.ready = !r_in_valid || w_out_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // port decode and state update for the access in stage one
    always_comb begin
        n_disk_port_b_out     = r_disk_port_b_out;
        n_disk_port_c_bits    = r_disk_port_c_bits;
        n_disk_to_host_nibble = r_disk_to_host_nibble;
        n_host_port_b_to_disk = r_host_port_b_to_disk;
        n_host_port_c_bits    = r_host_port_c_bits;
        n_host_to_disk_nibble = r_host_to_disk_nibble;
        n_disk_control_last   = r_disk_control_last;
        n_out.read_data       = READ_IDLE;
        n_out.handled         = 1'b0;
        n_out.wake_request    = 1'b0;

        unique case (r_in.mode)
            MODE_DISK_RD: begin
                unique case (r_in.port_address)
                    PORT_A: begin
                        n_out.read_data = r_host_port_b_to_disk;
                        n_out.handled   = 1'b1;
                    end
                    PORT_C: begin
                        n_out.read_data = {4'h0, r_host_to_disk_nibble};
                        n_out.handled   = 1'b1;
                    end
                    PORT_CTL: begin
                        n_out.read_data = r_disk_control_last;
                        n_out.handled   = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_DISK_WR: begin
                unique case (r_in.port_address)
                    PORT_B: begin
                        n_disk_port_b_out = r_in.write_data;
                        n_out.handled     = 1'b1;
                    end
                    PORT_CTL: begin
                        n_disk_control_last = r_in.write_data;
                        n_disk_port_c_bits  = fn_apply_control(r_disk_port_c_bits,
                                                               r_in.write_data);
                        // mode set leaves the nibble seen by the host alone
                        if (!r_in.write_data[7]) begin
                            n_disk_to_host_nibble = n_disk_port_c_bits[7:4];
                        end
                        n_out.handled = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_HOST_RD: begin
                unique case (r_in.port_address)
                    PORT_A: begin
                        n_out.read_data = r_disk_port_b_out;
                        n_out.handled   = 1'b1;
                    end
                    PORT_C: begin
                        n_out.read_data = {4'h0, r_disk_to_host_nibble};
                        n_out.handled   = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_HOST_WR: begin
                unique case (r_in.port_address)
                    PORT_B: begin
                        n_host_port_b_to_disk = r_in.write_data;
                        n_out.handled         = 1'b1;
                    end
                    PORT_C: begin
                        n_host_port_c_bits    = {r_in.write_data[7:4], 4'h0};
                        n_host_to_disk_nibble = r_in.write_data[7:4];
                        n_out.wake_request    = r_in.write_data[7];
                        n_out.handled         = 1'b1;
                    end
                    PORT_CTL: begin
                        n_host_port_c_bits = fn_apply_control(r_host_port_c_bits,
                                                              r_in.write_data);
                        if (!r_in.write_data[7]) begin
                            n_host_to_disk_nibble = n_host_port_c_bits[7:4];
                            n_out.wake_request    = n_host_port_c_bits[7];
                        end
                        n_out.handled = 1'b1;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    // control and port state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_disk_port_b_out     <= 8'h00;
            r_disk_port_c_bits    <= 8'h00;
            r_disk_to_host_nibble <= 4'h0;
            r_host_port_b_to_disk <= 8'h00;
            r_host_port_c_bits    <= 8'h00;
            r_host_to_disk_nibble <= 4'h0;
            r_disk_control_last   <= 8'h00;
        end else begin
            if (i_acc.ready) begin
                r_in_valid <= i_acc.valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_in_adv) begin
                r_disk_port_b_out     <= n_disk_port_b_out;
                r_disk_port_c_bits    <= n_disk_port_c_bits;
                r_disk_to_host_nibble <= n_disk_to_host_nibble;
                r_host_port_b_to_disk <= n_host_port_b_to_disk;
                r_host_port_c_bits    <= n_host_port_c_bits;
                r_host_to_disk_nibble <= n_host_to_disk_nibble;
                r_disk_control_last   <= n_disk_control_last;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_acc.ready && i_acc.valid) begin
            r_in <= i_acc.data;
        end
        if (w_in_adv) begin
            r_out <= n_out;
        end
    end

    `CHECK_PROP(a_unhandled_reads_ff,
        r_out_valid && !r_out.handled |-> r_out.read_data == READ_IDLE,
        "unhandled access returned data other than 0xFF")
    `CHECK_PROP(a_wake_needs_hit,
        r_out_valid && r_out.wake_request |-> r_out.handled,
        "wake flag on an unhandled access")
    `CHECK_PROP(a_stage_moves,
        w_in_adv |=> r_out_valid,
        "access left stage one without reaching the result register")
    `CHECK_ALWAYS(a_reset_empties,
        !i_rst_n |=> !r_in_valid && !r_out_valid,
        "pipeline not empty after reset")

endmodule

// ----- sim/cross_linked_ppi_port_pair_unit_tb.sv -----
// testbench for the linked parallel port pair: directed and random bus accesses
// checked word by word against a behavioral copy of both port images
// depends on clppi_pkg and clppi_stream_if
`timescale 1ns / 1ps

module cross_linked_ppi_port_pair_unit_tb;
    import clppi_pkg::*;

    localparam int RANDOM_ACCESSES = 1800;
    localparam int QUIET_TAIL      = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;

    logic i_clk;
    logic i_rst_n;

    clppi_stream_if #(.t_payload(t_access)) acc_if ();
    clppi_stream_if #(.t_payload(t_result)) res_if ();

    cross_linked_ppi_port_pair_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc_if),
        .o_res   (res_if)
    );

    // port images as both sides see them
    logic [7:0] disk_b_latch;
    logic [7:0] disk_c_image;
    logic [3:0] nibble_to_host;
    logic [7:0] host_b_latch;
    logic [7:0] host_c_image;
    logic [3:0] nibble_to_disk;
    logic [7:0] disk_ctl_byte;

    t_result expected_results[$];
    int      mismatch_count;
    int      stall_left;
    int      quiet_cycles;
    bit      idle_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // bit set/reset or mode set on one port c image
    function automatic logic [7:0] port_c_after_ctl(input logic [7:0] image,
                                                    input logic [7:0] ctl);
        logic [7:0] result_image;
        result_image = image;
        if (ctl[7]) begin
            result_image = 8'h00;
        end else begin
            result_image[ctl[3:1]] = ctl[0];
        end
        return result_image;
    endfunction

    function automatic t_result port_pair_access(input t_access acc);
        t_result r;
        r.read_data    = READ_IDLE;
        r.handled      = 1'b0;
        r.wake_request = 1'b0;
        case (acc.mode)
            MODE_DISK_RD: begin
                case (acc.port_address)
                    PORT_A:   begin r.read_data = host_b_latch;           r.handled = 1'b1; end
                    PORT_C:   begin r.read_data = {4'h0, nibble_to_disk}; r.handled = 1'b1; end
                    PORT_CTL: begin r.read_data = disk_ctl_byte;          r.handled = 1'b1; end
                    default: ;
                endcase
            end
            MODE_DISK_WR: begin
                case (acc.port_address)
                    PORT_B: begin
                        disk_b_latch = acc.write_data;
                        r.handled    = 1'b1;
                    end
                    PORT_CTL: begin
                        disk_ctl_byte = acc.write_data;
                        disk_c_image  = port_c_after_ctl(disk_c_image, acc.write_data);
                        if (!acc.write_data[7]) begin
                            nibble_to_host = disk_c_image[7:4];
                        end
                        r.handled = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_HOST_RD: begin
                case (acc.port_address)
                    PORT_A: begin r.read_data = disk_b_latch;           r.handled = 1'b1; end
                    PORT_C: begin r.read_data = {4'h0, nibble_to_host}; r.handled = 1'b1; end
                    default: ;
                endcase
            end
            default: begin
                case (acc.port_address)
                    PORT_B: begin
                        host_b_latch = acc.write_data;
                        r.handled    = 1'b1;
                    end
                    PORT_C: begin
                        host_c_image   = {acc.write_data[7:4], 4'h0};
                        nibble_to_disk = acc.write_data[7:4];
                        r.wake_request = acc.write_data[7];
                        r.handled      = 1'b1;
                    end
                    PORT_CTL: begin
                        host_c_image = port_c_after_ctl(host_c_image, acc.write_data);
                        // mode set leaves the forwarded nibble and wake alone
                        if (!acc.write_data[7]) begin
                            nibble_to_disk = host_c_image[7:4];
                            r.wake_request = host_c_image[7];
                        end
                        r.handled = 1'b1;
                    end
                    default: ;
                endcase
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned exp_val,
                                   input int unsigned got_val);
        $display("%0t mismatch %s: expected %0h got %0h", $time, field, exp_val, got_val);
        mismatch_count++;
    endtask

    // one word on the access channel, with an occasional gap in front
    task automatic send_access(input logic [1:0] mode, input logic [7:0] addr,
                               input logic [7:0] data);
        t_access acc;
        acc.mode         = mode;
        acc.port_address = addr;
        acc.write_data   = data;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            acc_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        acc_if.valid <= 1'b1;
        acc_if.data  <= acc;
        do @(posedge i_clk); while (!acc_if.ready);
        expected_results.push_back(port_pair_access(acc));
    endtask

    // result checking and receiver stalls
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", 0, 32'(res_if.data));
            end else begin
                exp_res = expected_results.pop_front();
                if (res_if.data.read_data !== exp_res.read_data)
                    report_mismatch("read_data", exp_res.read_data, res_if.data.read_data);
                if (res_if.data.handled !== exp_res.handled)
                    report_mismatch("handled", exp_res.handled, res_if.data.handled);
                if (res_if.data.wake_request !== exp_res.wake_request)
                    report_mismatch("wake_request", exp_res.wake_request,
                                    res_if.data.wake_request);
            end
        end
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((acc_if.valid && acc_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_reset_defaults;
        send_access(MODE_DISK_RD, PORT_A, 8'h3C);
        send_access(MODE_DISK_RD, PORT_C, 8'hC3);
        send_access(MODE_DISK_RD, PORT_CTL, 8'h00);
        send_access(MODE_HOST_RD, PORT_A, 8'hFF);
        send_access(MODE_HOST_RD, PORT_C, 8'h00);
        // control port is write only on the host side
        send_access(MODE_HOST_RD, PORT_CTL, 8'h00);
    endtask

    task automatic test_port_b_crossing;
        send_access(MODE_DISK_WR, PORT_B, 8'hA5);
        send_access(MODE_HOST_RD, PORT_A, 8'h00);
        send_access(MODE_HOST_WR, PORT_B, 8'h5A);
        send_access(MODE_DISK_RD, PORT_A, 8'hFF);
    endtask

    task automatic test_port_c_crossing;
        send_access(MODE_HOST_WR, PORT_C, 8'hF3);
        send_access(MODE_DISK_RD, PORT_C, 8'h00);
        send_access(MODE_HOST_WR, PORT_CTL, 8'h0E);
        send_access(MODE_HOST_WR, PORT_CTL, 8'h0F);
        send_access(MODE_HOST_WR, PORT_CTL, 8'h80);
        send_access(MODE_DISK_RD, PORT_C, 8'h00);
        send_access(MODE_DISK_WR, PORT_CTL, 8'h0D);
        send_access(MODE_HOST_RD, PORT_C, 8'h00);
        send_access(MODE_DISK_WR, PORT_CTL, 8'hFF);
        send_access(MODE_DISK_RD, PORT_CTL, 8'h00);
        send_access(MODE_HOST_RD, PORT_C, 8'h00);
    endtask

    task automatic test_unhandled_ports;
        send_access(MODE_DISK_WR, PORT_A, 8'h55);
        send_access(MODE_DISK_WR, PORT_C, 8'hAA);
        send_access(MODE_HOST_WR, PORT_A, 8'h00);
        send_access(MODE_DISK_RD, 8'h00, 8'hFF);
    endtask

    task automatic test_random_accesses;
        logic [1:0] mode;
        logic [7:0] addr;
        logic [7:0] data;
        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            // idling switches on and off in stretches, none at the tail
            if (n % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (n >= RANDOM_ACCESSES - QUIET_TAIL) idle_on = 1'b0;
            mode = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 85) begin
                addr = PORT_A + 8'($urandom_range(0, 3));
            end else begin
                addr = 8'($urandom_range(0, 255));
            end
            data = 8'($urandom_range(0, 255));
            // favor bit set/reset over mode set
            if (addr == PORT_CTL && $urandom_range(0, 9) < 7) data[7] = 1'b0;
            send_access(mode, addr, data);
        end
    endtask

    initial begin
        acc_if.valid   = 1'b0;
        acc_if.data    = '0;
        res_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        disk_b_latch   = '0;
        disk_c_image   = '0;
        nibble_to_host = '0;
        host_b_latch   = '0;
        host_c_image   = '0;
        nibble_to_disk = '0;
        disk_ctl_byte  = '0;
        mismatch_count = 0;
        stall_left     = 0;
        quiet_cycles   = 0;
        idle_on        = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_port_b_crossing();
        test_port_c_crossing();
        test_unhandled_ports();
        test_random_accesses();

        acc_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
